// ----- hdl/prf_pkg.sv -----
// Package for the polynomial root finder: widths, codes, state types.
// No dependencies.
`default_nettype none
package prf_pkg;
  localparam int MAX_ITER_DEF   = 64;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int DATA_WIDTH_DEF = 32;
  localparam int ITER_W         = 7;
  localparam int CFG_AW         = 5;

  typedef enum logic [1:0] {
    METH_BISECT = 2'd0,
    METH_FALSI  = 2'd1,
    METH_NEWTON = 2'd2,
    METH_SPARE  = 2'd3
  } method_t;

  typedef enum logic [1:0] {
    ST_CONV = 2'd0,
    ST_CAP  = 2'd1,
    ST_ZDEN = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    REG_METHOD = 3'd0,
    REG_TOL    = 3'd1,
    REG_C0     = 3'd2,
    REG_C1     = 3'd3,
    REG_C2     = 3'd4,
    REG_C3     = 3'd5,
    REG_C4     = 3'd6,
    REG_C5     = 3'd7
  } reg_idx_t;

  // Datapath operations of the shared unit
  typedef enum logic [2:0] {
    OP_MUL  = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_DIV  = 3'd3,
    OP_MID  = 3'd4
  } op_t;

  typedef enum logic [4:0] {
    S_IDLE, S_START, S_FX_EVAL, S_CHECK, S_D_EVAL, S_NEWT_DIV, S_NEWT_SUB,
    S_FA_EVAL, S_FB_EVAL, S_DEN, S_BA, S_RF_DIV, S_RF_SUB, S_MID, S_FX2_EVAL,
    S_SIGN, S_REFX, S_OUT
  } seq_state_t;

  typedef enum logic [1:0] {
    H_IDLE, H_MUL, H_ADD, H_DONE
  } horner_state_t;
endpackage
`default_nettype wire

// ----- hdl/prf_stream_if.sv -----
// Valid/ready channel interface carrying one word of payload.
// Depends on nothing.
`default_nettype none
interface prf_stream_if #(parameter int W = 32);
  logic         valid;
  logic         ready;
  logic [W-1:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ----- hdl/prf_alu.sv -----
// Shared saturating fixed-point unit: multiply, add, subtract, midpoint.
// Also holds the serial restoring divider for p*q/d. Uses prf_pkg.
`default_nettype none
module prf_alu #(
  parameter int DW = 32,
  parameter int FB = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire prf_pkg::op_t    op,
  input  wire logic [DW-1:0]   a,
  input  wire logic [DW-1:0]   b,
  input  wire logic [DW-1:0]   d,
  output logic                 done,
  output logic [DW-1:0]        y
);
  import prf_pkg::*;
  localparam int PW = 2 * DW;
  localparam int CW = $clog2(PW + 1);
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  logic          busy_r, busy_nxt;
  logic [1:0]    ph_r, ph_nxt;
  op_t           op_r, op_nxt;
  logic [DW-1:0] a_r, a_nxt, b_r, b_nxt, y_r, y_nxt;
  logic [PW-1:0] prod_r, prod_nxt;
  logic [DW:0]   den_r, den_nxt, rem_r, rem_nxt;
  logic [PW-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt, done_r, done_nxt;

  function automatic logic [DW-1:0] mag_f(input logic [DW-1:0] v);
    mag_f = v[DW-1] ? (~v + 1'b1) : v;
  endfunction

  // magnitude plus sign to saturated word
  function automatic logic [DW-1:0] sat_f(input logic neg, input logic [PW-1:0] m);
    logic big;
    big = (m[PW-1:DW-1] != '0);
    if (!neg) sat_f = big ? VMAX : m[DW-1:0];
    else if (big && (m != {{(PW-DW){1'b0}}, VMIN})) sat_f = VMIN;
    else sat_f = ~m[DW-1:0] + 1'b1;
  endfunction

  logic [DW:0]   sum_w, dif_w;
  logic [PW-1:0] rnd_w;
  logic [DW:0]   trial_w;
  logic [DW:0]   sh_w;

  always_comb begin
    sum_w   = {a[DW-1], a} + {b[DW-1], b};
    dif_w   = {a[DW-1], a} - {b[DW-1], b};
    rnd_w   = prod_r + (PW'(1) << (FB - 1));
    sh_w    = {rem_r[DW-1:0], prod_r[PW-1]};
    trial_w = sh_w - den_r;
  end

  always_comb begin
    busy_nxt = busy_r; ph_nxt = ph_r; op_nxt = op_r; a_nxt = a_r; b_nxt = b_r;
    y_nxt = y_r; prod_nxt = prod_r; den_nxt = den_r; rem_nxt = rem_r;
    q_nxt = q_r; cnt_nxt = cnt_r; neg_nxt = neg_r; done_nxt = 1'b0;
    if (start) begin
      op_nxt = op;
      neg_nxt = a[DW-1] ^ b[DW-1];
      a_nxt = mag_f(a); b_nxt = mag_f(b);
      case (op)
        OP_ADD: begin
          y_nxt = (sum_w[DW] != sum_w[DW-1]) ? (sum_w[DW] ? VMIN : VMAX) : sum_w[DW-1:0];
          done_nxt = 1'b1;
        end
        OP_SUB: begin
          y_nxt = (dif_w[DW] != dif_w[DW-1]) ? (dif_w[DW] ? VMIN : VMAX) : dif_w[DW-1:0];
          done_nxt = 1'b1;
        end
        OP_MID: begin
          y_nxt = sum_w[DW:1];
          done_nxt = 1'b1;
        end
        OP_DIV: begin
          neg_nxt = a[DW-1] ^ b[DW-1] ^ d[DW-1];
          den_nxt = {1'b0, mag_f(d)};
          busy_nxt = 1'b1; ph_nxt = 2'd0;
        end
        default: begin
          busy_nxt = 1'b1; ph_nxt = 2'd0;
        end
      endcase
    end else if (busy_r) begin
      case (ph_r)
        2'd0: begin
          // one registered multiply of magnitudes
          prod_nxt = PW'(a_r) * PW'(b_r);
          ph_nxt = 2'd1;
        end
        2'd1: begin
          if (op_r == OP_MUL) begin
            y_nxt = sat_f(neg_r, PW'(rnd_w >> FB));
            busy_nxt = 1'b0; done_nxt = 1'b1;
          end else begin
            if (prod_r == '0) neg_nxt = 1'b0;
            rem_nxt = '0; q_nxt = '0; cnt_nxt = CW'(PW);
            ph_nxt = 2'd2;
          end
        end
        2'd2: begin
          // one quotient bit a cycle
          if (!trial_w[DW]) begin
            rem_nxt = trial_w; q_nxt = {q_r[PW-2:0], 1'b1};
          end else begin
            rem_nxt = sh_w; q_nxt = {q_r[PW-2:0], 1'b0};
          end
          prod_nxt = {prod_r[PW-2:0], 1'b0};
          cnt_nxt = cnt_r - 1'b1;
          if (cnt_r == CW'(1)) ph_nxt = 2'd3;
        end
        default: begin
          y_nxt = sat_f(neg_r, q_r);
          busy_nxt = 1'b0; done_nxt = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; done_r <= done_nxt;
    end
    ph_r <= ph_nxt; op_r <= op_nxt; a_r <= a_nxt; b_r <= b_nxt; y_r <= y_nxt;
    prod_r <= prod_nxt; den_r <= den_nxt; rem_r <= rem_nxt; q_r <= q_nxt;
    cnt_r <= cnt_nxt; neg_r <= neg_nxt;
  end

  assign done = done_r;
  assign y    = y_r;
endmodule
`default_nettype wire

// ----- hdl/prf_horner.sv -----
// Horner sequencer: evaluates p(x) or p'(x) through the shared unit.
// Uses prf_pkg and is wired to prf_alu by the top level.
`default_nettype none
module prf_horner #(
  parameter int DW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 start,
  input  wire logic                 deriv,
  input  wire logic [DW-1:0]        x,
  input  wire logic [6*DW-1:0]      coefs,
  output logic                      done,
  output logic [DW-1:0]             val,
  output logic                      alu_start,
  output prf_pkg::op_t              alu_op,
  output logic [DW-1:0]             alu_a,
  output logic [DW-1:0]             alu_b,
  input  wire logic                 alu_done,
  input  wire logic [DW-1:0]        alu_y
);
  import prf_pkg::*;
  localparam logic [DW-1:0] VMAX = {1'b0, {(DW-1){1'b1}}};
  localparam logic [DW-1:0] VMIN = {1'b1, {(DW-1){1'b0}}};

  horner_state_t st_r, st_nxt;
  logic [2:0]    k_r, k_nxt;
  logic [DW-1:0] acc_r, acc_nxt, x_r, x_nxt;
  logic          der_r, der_nxt, go_r, go_nxt;

  function automatic logic [DW-1:0] cf(input logic [6*DW-1:0] c, input logic [2:0] i);
    cf = c[i*DW +: DW];
  endfunction

  // k*coef_k saturated: k is at most 5, so a wider product and clamp is exact
  function automatic logic [DW-1:0] dcf(input logic [6*DW-1:0] c, input logic [2:0] i);
    logic signed [DW+3:0] s;
    s = $signed({{4{c[i*DW+DW-1]}}, c[i*DW +: DW]}) * $signed({1'b0, 3'(i)});
    if (s > $signed({{4{1'b0}}, VMAX})) dcf = VMAX;
    else if (s < $signed({{4{1'b1}}, VMIN})) dcf = VMIN;
    else dcf = s[DW-1:0];
  endfunction

  logic [DW-1:0] term_w;
  assign term_w = der_r ? dcf(coefs, k_r) : cf(coefs, k_r);

  always_comb begin
    st_nxt = st_r; k_nxt = k_r; acc_nxt = acc_r; x_nxt = x_r; der_nxt = der_r;
    go_nxt = 1'b0; done = 1'b0;
    alu_op = OP_MUL; alu_a = acc_r; alu_b = x_r;
    case (st_r)
      H_IDLE: begin
        if (start) begin
          x_nxt = x; der_nxt = deriv;
          acc_nxt = deriv ? dcf(coefs, 3'd5) : cf(coefs, 3'd5);
          k_nxt = 3'd4;
          go_nxt = 1'b1; st_nxt = H_MUL;
        end
      end
      H_MUL: begin
        if (alu_done) begin
          acc_nxt = alu_y; go_nxt = 1'b1; st_nxt = H_ADD;
        end
      end
      H_ADD: begin
        alu_op = OP_ADD; alu_b = term_w;
        if (alu_done) begin
          acc_nxt = alu_y;
          if (k_r == (der_r ? 3'd1 : 3'd0)) st_nxt = H_DONE;
          else begin
            k_nxt = k_r - 1'b1; go_nxt = 1'b1; st_nxt = H_MUL;
          end
        end
      end
      default: begin
        done = 1'b1; st_nxt = H_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= H_IDLE; go_r <= 1'b0;
    end else begin
      st_r <= st_nxt; go_r <= go_nxt;
    end
    k_r <= k_nxt; acc_r <= acc_nxt; x_r <= x_nxt; der_r <= der_nxt;
  end

  assign alu_start = go_r;
  assign val       = acc_r;
endmodule
`default_nettype wire

// ----- hdl/polynomial_root_finder.sv -----
// Top level of the polynomial root finder: APB registers, request sequencer,
// Horner sequencer and shared arithmetic unit. Uses prf_pkg, prf_stream_if.
//
// Finds one root of a degree-5 Q16.16 polynomial by bisection, regula falsi
// or Newton (register method), stopping when |p(x)| <= tolerance, at
// MAX_ITER steps, or on a zero denominator. One word is taken at a time; the
// block is busy until the result word is taken. All arithmetic runs through
// one shared saturating unit: a multiply passes a registered product and a
// rounding step, an add gives a registered result, and a division works one
// quotient bit a cycle over the 64-bit product. A Horner pass runs a multiply
// and an add per coefficient. The total time grows with the iteration count,
// plus any wait on the result side.
`default_nettype none
module polynomial_root_finder #(
  parameter int MAX_ITER   = prf_pkg::MAX_ITER_DEF,
  parameter int FRAC_BITS  = prf_pkg::FRAC_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  prf_stream_if.sink                        in_ch,
  prf_stream_if.source                      out_ch,
  input  wire logic                         cfg_psel,
  input  wire logic                         cfg_penable,
  input  wire logic                         cfg_pwrite,
  input  wire logic [prf_pkg::CFG_AW-1:0]   cfg_paddr,
  input  wire logic [31:0]                  cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import prf_pkg::*;
  localparam int DW = DATA_WIDTH_DEF;
  localparam logic [DW-1:0] ONE = DW'(1) << FRAC_BITS;

  // ---------------- registers
  logic [1:0]     method_r;
  logic [30:0]    tol_r;
  logic [DW-1:0]  coef_r [6];
  logic [6*DW-1:0] coefs_w;
  reg_idx_t       widx;
  logic           wr;

  assign widx = reg_idx_t'(cfg_paddr[4:2]);
  assign wr   = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      method_r <= METH_BISECT;
      tol_r <= 31'd66;
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
    end else if (wr) begin
      case (widx)
        REG_METHOD: method_r <= cfg_pwdata[1:0];
        REG_TOL:    tol_r <= cfg_pwdata[30:0];
        default:    coef_r[widx - REG_C0] <= DW'(signed'(cfg_pwdata));
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 6; i++) coefs_w[i*DW +: DW] = coef_r[i];
    case (widx)
      REG_METHOD: cfg_prdata = {30'd0, method_r};
      REG_TOL:    cfg_prdata = {1'b0, tol_r};
      default:    cfg_prdata = 32'(coef_r[widx - REG_C0]);
    endcase
  end

  // ---------------- shared unit and Horner sequencer
  logic          h_start, h_deriv, h_done;
  logic [DW-1:0] h_x, h_val;
  logic          ha_start, sa_start, alu_start, alu_done;
  op_t           ha_op, sa_op, alu_op;
  logic [DW-1:0] ha_a, ha_b, sa_a, sa_b, sa_d, alu_a, alu_b, alu_y;
  logic          h_busy;

  prf_horner #(.DW(DW)) u_horner (
    .clk, .rst_n, .start(h_start), .deriv(h_deriv), .x(h_x), .coefs(coefs_w),
    .done(h_done), .val(h_val), .alu_start(ha_start), .alu_op(ha_op),
    .alu_a(ha_a), .alu_b(ha_b), .alu_done(alu_done), .alu_y(alu_y)
  );

  assign alu_start = ha_start | sa_start;
  assign alu_op    = h_busy ? ha_op : sa_op;
  assign alu_a     = h_busy ? ha_a : sa_a;
  assign alu_b     = h_busy ? ha_b : sa_b;

  prf_alu #(.DW(DW), .FB(FRAC_BITS)) u_alu (
    .clk, .rst_n, .start(alu_start), .op(alu_op), .a(alu_a), .b(alu_b),
    .d(sa_d), .done(alu_done), .y(alu_y)
  );

  // ---------------- request sequencer
  seq_state_t    st_r, st_nxt;
  logic [DW-1:0] a_r, a_nxt, b_r, b_nxt, x_r, x_nxt, fx_r, fx_nxt;
  logic [DW-1:0] fa_r, fa_nxt, t_r, t_nxt, u_r, u_nxt;
  logic [10:0]   n_r, n_nxt;
  status_t       stat_r, stat_nxt;
  logic          wait_r, wait_nxt;
  logic [DW-1:0] start_pt;
  logic [DW-1:0] fx_mag;

  assign start_pt = in_ch.data[3*DW-1 -: DW];
  assign fx_mag   = fx_r[DW-1] ? (~fx_r + 1'b1) : fx_r;
  assign h_busy   = (st_r == S_FX_EVAL) || (st_r == S_D_EVAL) || (st_r == S_FA_EVAL)
                 || (st_r == S_FB_EVAL) || (st_r == S_FX2_EVAL) || (st_r == S_REFX);
  assign in_ch.ready  = (st_r == S_IDLE);
  assign out_ch.valid = (st_r == S_OUT);
  assign out_ch.data  = {x_r, fx_r, ITER_W'(n_r), stat_r};

  always_comb begin
    st_nxt = st_r; a_nxt = a_r; b_nxt = b_r; x_nxt = x_r; fx_nxt = fx_r;
    fa_nxt = fa_r; t_nxt = t_r; u_nxt = u_r; n_nxt = n_r; stat_nxt = stat_r;
    wait_nxt = wait_r;
    h_start = 1'b0; h_deriv = 1'b0; h_x = x_r;
    sa_start = 1'b0; sa_op = OP_ADD; sa_a = '0; sa_b = '0; sa_d = u_r;
    case (st_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          a_nxt = in_ch.data[DW-1:0];
          b_nxt = in_ch.data[2*DW-1:DW];
          x_nxt = (method_r == METH_NEWTON) ? start_pt : in_ch.data[2*DW-1:DW];
          n_nxt = '0; stat_nxt = ST_CONV; wait_nxt = 1'b0;
          st_nxt = S_FX_EVAL;
        end
      end
      S_FX_EVAL, S_REFX: begin
        h_x = x_r;
        if (!wait_r) begin h_start = 1'b1; wait_nxt = 1'b1; end
        else if (h_done) begin fx_nxt = h_val; wait_nxt = 1'b0; st_nxt = S_CHECK; end
      end
      S_CHECK: begin
        if ({{(DW-31){1'b0}}, tol_r} >= fx_mag) st_nxt = S_OUT;
        else if (n_r >= 11'(MAX_ITER)) begin stat_nxt = ST_CAP; st_nxt = S_OUT; end
        else if (method_r == METH_NEWTON) st_nxt = S_D_EVAL;
        else st_nxt = S_FA_EVAL;
      end
      S_D_EVAL: begin
        h_x = x_r; h_deriv = 1'b1;
        if (!wait_r) begin h_start = 1'b1; wait_nxt = 1'b1; end
        else if (h_done) begin
          wait_nxt = 1'b0; u_nxt = h_val;
          if (h_val == '0) begin stat_nxt = ST_ZDEN; st_nxt = S_OUT; end
          else st_nxt = S_NEWT_DIV;
        end
      end
      S_NEWT_DIV: begin
        sa_op = OP_DIV; sa_a = fx_r; sa_b = ONE; sa_d = u_r;
        if (!wait_r) begin sa_start = 1'b1; wait_nxt = 1'b1; end
        else if (alu_done) begin t_nxt = alu_y; wait_nxt = 1'b0; st_nxt = S_NEWT_SUB; end
      end
      S_NEWT_SUB: begin
        sa_op = OP_SUB; sa_a = x_r; sa_b = t_r;
        if (!wait_r) begin sa_start = 1'b1; wait_nxt = 1'b1; end
        else if (alu_done) begin
          x_nxt = alu_y; wait_nxt = 1'b0; n_nxt = n_r + 1'b1; st_nxt = S_REFX;
        end
      end
      S_FA_EVAL: begin
        h_x = a_r;
        if (!wait_r) begin h_start = 1'b1; wait_nxt = 1'b1; end
        else if (h_done) begin
          fa_nxt = h_val; wait_nxt = 1'b0;
          st_nxt = (method_r == METH_FALSI) ? S_FB_EVAL : S_MID;
        end
      end
      S_FB_EVAL: begin
        h_x = b_r;
        if (!wait_r) begin h_start = 1'b1; wait_nxt = 1'b1; end
        else if (h_done) begin t_nxt = h_val; wait_nxt = 1'b0; st_nxt = S_DEN; end
      end
      S_DEN: begin
        sa_op = OP_SUB; sa_a = t_r; sa_b = fa_r;
        if (!wait_r) begin sa_start = 1'b1; wait_nxt = 1'b1; end
        else if (alu_done) begin
          u_nxt = alu_y; wait_nxt = 1'b0;
          if (alu_y == '0) begin stat_nxt = ST_ZDEN; st_nxt = S_OUT; end
          else st_nxt = S_BA;
        end
      end
      S_BA: begin
        sa_op = OP_SUB; sa_a = b_r; sa_b = a_r;
        if (!wait_r) begin sa_start = 1'b1; wait_nxt = 1'b1; end
        else if (alu_done) begin t_nxt = alu_y; wait_nxt = 1'b0; st_nxt = S_RF_DIV; end
      end
      S_RF_DIV: begin
        sa_op = OP_DIV; sa_a = fa_r; sa_b = t_r; sa_d = u_r;
        if (!wait_r) begin sa_start = 1'b1; wait_nxt = 1'b1; end
        else if (alu_done) begin t_nxt = alu_y; wait_nxt = 1'b0; st_nxt = S_RF_SUB; end
      end
      S_RF_SUB: begin
        sa_op = OP_SUB; sa_a = a_r; sa_b = t_r;
        if (!wait_r) begin sa_start = 1'b1; wait_nxt = 1'b1; end
        else if (alu_done) begin x_nxt = alu_y; wait_nxt = 1'b0; st_nxt = S_FX2_EVAL; end
      end
      S_MID: begin
        sa_op = OP_MID; sa_a = a_r; sa_b = b_r;
        if (!wait_r) begin sa_start = 1'b1; wait_nxt = 1'b1; end
        else if (alu_done) begin x_nxt = alu_y; wait_nxt = 1'b0; st_nxt = S_FX2_EVAL; end
      end
      S_FX2_EVAL: begin
        h_x = x_r;
        if (!wait_r) begin h_start = 1'b1; wait_nxt = 1'b1; end
        else if (h_done) begin fx_nxt = h_val; wait_nxt = 1'b0; st_nxt = S_SIGN; end
      end
      S_SIGN: begin
        // b moves only on a strict sign change between p(a) and p(x)
        if (fa_r != '0 && fx_r != '0 && (fa_r[DW-1] != fx_r[DW-1])) b_nxt = x_r;
        else a_nxt = x_r;
        n_nxt = n_r + 1'b1;
        st_nxt = S_REFX;
      end
      S_OUT: begin
        if (out_ch.ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; wait_r <= 1'b0;
    end else begin
      st_r <= st_nxt; wait_r <= wait_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; x_r <= x_nxt; fx_r <= fx_nxt; fa_r <= fa_nxt;
    t_r <= t_nxt; u_r <= u_nxt; n_r <= n_nxt; stat_r <= stat_nxt;
  end
endmodule
`default_nettype wire

// ----- tb/sv/prf_checker.sv -----
// Checker for the polynomial root finder: watches the register port and both
// channels, predicts each result word and compares it. Uses prf_pkg, prf_stream_if.
`timescale 1ns / 1ps
module prf_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  prf_stream_if                      in_ch,
  prf_stream_if                      out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [prf_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                cfg_pwdata,
  input  logic                       cfg_pready,
  output int                         errors,
  output int                         outstanding
);
  import prf_pkg::*;

  typedef logic signed [31:0] q_t;

  typedef struct packed {
    q_t          root;
    q_t          residual;
    logic [6:0]  iters;
    status_t     status;
  } answer_t;

  localparam longint QMAX = 64'sd2147483647;
  localparam longint QMIN = -64'sd2147483648;
  localparam int     CAP  = MAX_ITER_DEF;

  // Shadow copy of the registers
  method_t     meth;
  logic [30:0] tol;
  q_t          coef [6];

  answer_t     expected_q [$];

  function automatic q_t clamp(longint v);
    if (v > QMAX) return q_t'(QMAX);
    if (v < QMIN) return q_t'(QMIN);
    return q_t'(v);
  endfunction

  function automatic q_t q_add(q_t a, q_t b);
    return clamp(longint'(a) + longint'(b));
  endfunction

  function automatic q_t q_sub(q_t a, q_t b);
    return clamp(longint'(a) - longint'(b));
  endfunction

  // Product rounded on its magnitude, ties away from zero
  function automatic q_t q_mul(q_t a, q_t b);
    longint p;
    longint unsigned m;
    p = longint'(a) * longint'(b);
    m = (p < 0) ? longint'(-p) : p;
    m = (m + 64'd32768) >> FRAC_BITS_DEF;
    return (p < 0) ? clamp(-longint'(m)) : clamp(longint'(m));
  endfunction

  // p*q/d truncated toward zero; d nonzero
  function automatic q_t q_muldiv(q_t p, q_t q, q_t d);
    longint prod;
    longint unsigned pm, dm, qt;
    bit neg;
    prod = longint'(p) * longint'(q);
    pm = (prod < 0) ? longint'(-prod) : prod;
    dm = (d < 0) ? longint'(-longint'(d)) : longint'(d);
    qt = pm / dm;
    neg = (prod < 0) != (d < 0);
    if (p == 0 || q == 0) neg = 0;
    return neg ? clamp(-longint'(qt)) : clamp(longint'(qt));
  endfunction

  function automatic q_t horner(q_t x);
    q_t acc;
    acc = coef[5];
    for (int k = 4; k >= 0; k--) acc = q_add(q_mul(acc, x), coef[k]);
    return acc;
  endfunction

  function automatic q_t slope(q_t x);
    q_t acc;
    acc = clamp(5 * longint'(coef[5]));
    for (int k = 4; k >= 1; k--) acc = q_add(q_mul(acc, x), clamp(k * longint'(coef[k])));
    return acc;
  endfunction

  function automatic bit close_enough(q_t fx);
    longint m;
    m = (fx < 0) ? -longint'(fx) : longint'(fx);
    return m <= longint'({1'b0, tol});
  endfunction

  function automatic answer_t solve_root(q_t lo, q_t hi, q_t start);
    q_t a, b, x, fx, fa, d, den;
    int n;
    answer_t r;
    a = lo;
    b = hi;
    n = 0;
    r.status = ST_CONV;
    x = (meth == METH_NEWTON) ? start : hi;
    fx = horner(x);
    while (!close_enough(fx)) begin
      if (n >= CAP) begin
        r.status = ST_CAP;
        break;
      end
      if (meth == METH_NEWTON) begin
        d = slope(x);
        if (d == 0) begin
          r.status = ST_ZDEN;
          break;
        end
        x = q_sub(x, q_muldiv(fx, 32'sd65536, d));
      end else begin
        fa = horner(a);
        if (meth == METH_FALSI) begin
          den = q_sub(horner(b), fa);
          if (den == 0) begin
            r.status = ST_ZDEN;
            break;
          end
          x = q_sub(a, q_muldiv(fa, q_sub(b, a), den));
        end else begin
          x = q_t'((longint'(a) + longint'(b)) >>> 1);
        end
        fx = horner(x);
        // b moves only on a strict sign change
        if (fa != 0 && fx != 0 && ((fa < 0) != (fx < 0))) b = x;
        else a = x;
      end
      n++;
      fx = horner(x);
    end
    r.root = x;
    r.residual = fx;
    r.iters = 7'(n);
    return r;
  endfunction

  assign outstanding = expected_q.size();

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst_n) begin
      meth <= METH_BISECT;
      tol <= 31'd66;
      for (int k = 0; k < 6; k++) coef[k] <= '0;
      errors <= 0;
    end else begin
      // Register writes
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[4:2]))
          REG_METHOD: meth <= method_t'(cfg_pwdata[1:0]);
          REG_TOL:    tol <= cfg_pwdata[30:0];
          default:    coef[cfg_paddr[4:2] - REG_C0] <= cfg_pwdata;
        endcase
      end
      // Request word: predict its answer
      if (in_ch.valid && in_ch.ready)
        expected_q.insert(expected_q.size(),
                          solve_root(in_ch.data[31:0], in_ch.data[63:32],
                                     in_ch.data[95:64]));
      // Result word: compare with the oldest answer
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.data[72:41], out_ch.data[40:9], out_ch.data[8:2],
               status_t'(out_ch.data[1:0])};
        if (expected_q.size() == 0) begin
          errors <= errors + 1;
          if (errors < 10) $display("unexpected result word %h", out_ch.data);
        end else begin
          want = expected_q.pop_front();
          if (got != want) begin
            errors <= errors + 1;
            if (errors < 10)
              $display("mismatch: root %h/%h residual %h/%h iters %0d/%0d status %0d/%0d",
                       want.root, got.root, want.residual, got.residual,
                       want.iters, got.iters, want.status, got.status);
          end
        end
      end
    end
  end
endmodule

// ----- tb/sv/tb_polynomial_root_finder.sv -----
// Testbench top for the polynomial root finder: clock, reset, register writes,
// request and result traffic, verdict. Uses prf_pkg, prf_stream_if, prf_checker.
`timescale 1ns / 1ps
module tb_polynomial_root_finder;
  import prf_pkg::*;

  typedef logic signed [31:0] q_t;

  localparam longint CYCLE_LIMIT = 64'd100_000_000;

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;
  int errors, outstanding;
  bit calm = 0;        // no idling on either side
  bit hold_go = 0;     // asks the receiver for a long hold-off
  longint cycles = 0;

  prf_stream_if #(.W(96)) in_ch ();
  prf_stream_if #(.W(73)) out_ch ();

  polynomial_root_finder dut (
    .clk, .rst_n, .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata,
    .cfg_prdata, .cfg_pready
  );

  prf_checker chk (
    .clk, .rst_n, .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .errors, .outstanding
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // Timeout watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_polynomial_root_finder failed");
      $finish;
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    out_ch.ready = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 0;
        hold_left = 3000;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 0;
      end else begin
        out_ch.ready <= calm || ($urandom_range(99) >= 26);
      end
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] value);
    cfg_psel <= 1;
    cfg_penable <= 0;
    cfg_pwrite <= 1;
    cfg_paddr <= CFG_AW'(idx) << 2;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0;
    cfg_penable <= 0;
    cfg_pwrite <= 0;
    @(negedge clk);
  endtask

  task automatic load_setup(method_t m, logic [30:0] tol, q_t c0, q_t c1, q_t c2,
                            q_t c3, q_t c4, q_t c5);
    reg_write(REG_METHOD, 32'(m));
    reg_write(REG_TOL, {1'b0, tol});
    reg_write(REG_C0, c0);
    reg_write(REG_C1, c1);
    reg_write(REG_C2, c2);
    reg_write(REG_C3, c3);
    reg_write(REG_C4, c4);
    reg_write(REG_C5, c5);
  endtask

  // Offer one request word, holding it until taken
  task automatic send(q_t lo, q_t hi, q_t start);
    if (!calm)
      while ($urandom_range(99) < 26) begin
        in_ch.valid <= 0;
        @(negedge clk);
      end
    in_ch.valid <= 1;
    in_ch.data <= {start, hi, lo};
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Wait for every answer, then let the block settle
  task automatic drain();
    in_ch.valid <= 0;
    while (outstanding != 0) @(negedge clk);
    repeat (50) @(negedge clk);
  endtask

  function automatic q_t small_val(int span);
    return q_t'($urandom_range(2 * span) - span);
  endfunction

  task automatic random_batch(int n);
    q_t lo, hi, st, t;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 12) begin
        lo = $urandom;
        hi = $urandom;
        st = $urandom;
      end else begin
        lo = -q_t'($urandom_range(1 << 21));
        hi = q_t'($urandom_range(1 << 21));
        st = small_val(1 << 20);
        if ($urandom_range(9) == 0) begin
          t = lo;
          lo = hi;
          hi = t;
        end
      end
      send(lo, hi, st);
    end
  endtask

  initial begin
    q_t c [6];
    logic [30:0] tol;
    in_ch.valid = 0;
    in_ch.data = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // Directed: zero polynomial converges at once
    send(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    send(32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    drain();
    // x - 1.5, each method, plus the spare method code
    load_setup(METH_BISECT, 31'd66, -32'sd98304, 32'sd65536, 0, 0, 0, 0);
    send(0, 32'sd262144, 0);
    send(32'sd262144, 0, 0);                 // reversed bracket
    send(32'sh8000_0000, 32'sh7fff_ffff, 0);
    drain();
    reg_write(REG_METHOD, 32'(METH_FALSI));
    send(0, 32'sd262144, 0);
    send(32'sd131072, 32'sd262144, 0);       // non-bracketing
    drain();
    reg_write(REG_METHOD, 32'(METH_NEWTON));
    send(0, 0, 32'sd262144);
    send(0, 0, 32'sh7fff_ffff);
    drain();
    reg_write(REG_METHOD, 32'(METH_SPARE));
    send(0, 32'sd262144, 0);
    drain();
    // Constant polynomial: cap for bisection, zero denominator otherwise
    load_setup(METH_BISECT, 31'd0, 32'sd327680, 0, 0, 0, 0, 0);
    send(-32'sd65536, 32'sd65536, 0);
    drain();
    reg_write(REG_METHOD, 32'(METH_FALSI));
    send(-32'sd65536, 32'sd65536, 0);
    drain();
    reg_write(REG_METHOD, 32'(METH_NEWTON));
    send(0, 0, 32'sd65536);
    drain();
    // Extreme coefficients, saturating everywhere; widest tolerance
    load_setup(METH_NEWTON, 31'h7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff,
               32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff);
    send(32'sh8000_0000, 32'sh7fff_ffff, 32'sh8000_0000);
    drain();
    reg_write(REG_TOL, 32'd0);
    send(0, 0, 32'sh7fff_ffff);
    send(0, 0, 32'sd65536);
    drain();
    reg_write(REG_METHOD, 32'(METH_BISECT));
    send(32'sh8000_0000, 32'sh7fff_ffff, 0);
    drain();

    // Random phases, one config each
    for (int ph = 0; ph < 12; ph++) begin
      for (int k = 0; k < 6; k++) begin
        if ($urandom_range(99) < 6) c[k] = $urandom;
        else if (k > 1 && $urandom_range(99) < 45) c[k] = 0;
        else c[k] = small_val(k == 0 ? (1 << 19) : (1 << 18));
      end
      case ($urandom_range(3))
        0:       tol = 0;
        1:       tol = 31'd66;
        2:       tol = 31'($urandom_range(1, 1 << 16));
        default: tol = 31'($urandom);
      endcase
      calm = (ph == 4);
      load_setup(method_t'(ph % 4), tol, c[0], c[1], c[2], c[3], c[4], c[5]);
      if (ph == 6) hold_go = 1;
      random_batch(125);
      drain();
    end

    if (errors == 0) begin
      $display("tb_polynomial_root_finder passed");
    end else begin
      $display("tb_polynomial_root_finder failed");
    end
    $finish;
  end
endmodule

// ----- polynomial_root_finder.f -----
hdl/prf_pkg.sv
hdl/prf_stream_if.sv
hdl/prf_alu.sv
hdl/prf_horner.sv
hdl/polynomial_root_finder.sv
tb/sv/prf_checker.sv
tb/sv/tb_polynomial_root_finder.sv
